// File: hdl/psm_pkg.sv
// ----------------------------------------------------------------------------
// psm_pkg
// Types, constants and helpers shared by the planar shadow matrix block.
// ----------------------------------------------------------------------------
package psm_pkg;

  localparam int unsigned QDepth = 8;
  localparam int unsigned QAw    = 3;
  localparam int unsigned CrdW   = 4;
  localparam int unsigned ScW    = 31;
  localparam int unsigned MagW   = 67;
  localparam int unsigned AccW   = 104;
  localparam int unsigned EntW   = 48;

  localparam logic [2:0] CFG_LIGHT_X = 3'd0;
  localparam logic [2:0] CFG_LIGHT_Y = 3'd1;
  localparam logic [2:0] CFG_LIGHT_Z = 3'd2;
  localparam logic [2:0] CFG_LIGHT_W = 3'd3;

  // classified item handed from front to back
  typedef struct packed {
    logic [2:0][ScW-1:0] sc;
    logic [2:0]          neg;
    logic [2:0][31:0]    c;
  } q_entry_t;

  typedef struct packed {
    logic [1:0]           row_index;
    logic [3:0][EntW-1:0] entry;
    logic                 last_row;
  } row_t;

  // round Q.62 to Q.16 and saturate to 48 bits
  function automatic logic [EntW-1:0] to_entry(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] t;
    logic [57:0]            s;
    logic [EntW-1:0]        r;
    t = v + AccW'(64'h0000_2000_0000_0000);
    s = t[AccW-1:46];
    if (s[57:47] == {11{s[47]}}) begin
      r = s[47:0];
    end else if (s[57]) begin
      r = {1'b1, 47'd0};
    end else begin
      r = {1'b0, {47{1'b1}}};
    end
    return r;
  endfunction

endpackage

// File: hdl/planar_shadow_matrix.sv
// ----------------------------------------------------------------------------
// planar_shadow_matrix
// Builds the planar projected shadow matrix from three plane points and a
// homogeneous light position, one matrix row per output item.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+--------------------------
//  input    | point_{a,b,c}_{x,y,z}_i                 | start high, busy low
//  result   | row_index_o, entry_0..3_o, last_row_o   | strobe_o, one cycle
//  config   | cfg_we_i, cfg_idx_i, cfg_wdata_i        | cfg_we_i high
//
// Order: an item passes the front's difference, product, magnitude and entry
// registers before it reaches the queue. The back takes each item through pop,
// square and sum, a bit-serial square root, set-up and a bit-serial normal
// divide, the plane offset, then the dot product and the four rows.
// The back unit sets the sustained rate: it pops a new item only when idle.
// The queue lets up to eight items be taken while the back is busy.
// Reset clears all control state and the light registers.
// The receiver cannot stall: each row is shown for one cycle.
// ----------------------------------------------------------------------------
module planar_shadow_matrix (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] point_a_x_i,
  input  logic [31:0] point_a_y_i,
  input  logic [31:0] point_a_z_i,
  input  logic [31:0] point_b_x_i,
  input  logic [31:0] point_b_y_i,
  input  logic [31:0] point_b_z_i,
  input  logic [31:0] point_c_x_i,
  input  logic [31:0] point_c_y_i,
  input  logic [31:0] point_c_z_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        strobe_o,
  output logic [1:0]  row_index_o,
  output logic [47:0] entry_0_o,
  output logic [47:0] entry_1_o,
  output logic [47:0] entry_2_o,
  output logic [47:0] entry_3_o,
  output logic        last_row_o
);

  logic [3:0][31:0]            light_q;
  logic [psm_pkg::CrdW-1:0]    crd_q;
  logic                        accept;
  logic                        push, pop, q_valid;
  psm_pkg::q_entry_t           push_data, q_data;
  psm_pkg::row_t               res;
  logic                        res_valid;
  logic [8:0][31:0]            pts;

  // light registers: writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        psm_pkg::CFG_LIGHT_X: light_q[0] <= cfg_wdata_i;
        psm_pkg::CFG_LIGHT_Y: light_q[1] <= cfg_wdata_i;
        psm_pkg::CFG_LIGHT_Z: light_q[2] <= cfg_wdata_i;
        psm_pkg::CFG_LIGHT_W: light_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // credit count: items taken but not yet popped by the back
  assign busy   = (crd_q == psm_pkg::CrdW'(psm_pkg::QDepth));
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crd_q <= '0;
    end else begin
      crd_q <= crd_q + psm_pkg::CrdW'(accept) - psm_pkg::CrdW'(pop);
    end
  end

  assign pts = {point_c_z_i, point_c_y_i, point_c_x_i,
                point_b_z_i, point_b_y_i, point_b_x_i,
                point_a_z_i, point_a_y_i, point_a_x_i};

  psm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (accept),
    .pts_i      (pts),
    .push_o     (push),
    .entry_o    (push_data)
  );

  psm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  psm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (pop),
    .light_i     (light_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign strobe_o    = res_valid;
  assign row_index_o = res.row_index;
  assign entry_0_o   = res.entry[0];
  assign entry_1_o   = res.entry[1];
  assign entry_2_o   = res.entry[2];
  assign entry_3_o   = res.entry[3];
  assign last_row_o  = res.last_row;

  // hold the credit count within the queue depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    crd_q <= psm_pkg::CrdW'(psm_pkg::QDepth))
    else $error("credit count beyond queue depth");

  // last row flag only on row three
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (last_row_o == (row_index_o == 2'd3)))
    else $error("last row flag mismatch");

  // a pop needs a waiting item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (q_valid && crd_q != '0))
    else $error("pop from empty queue");

endmodule

// File: hdl/psm_front.sv
// ----------------------------------------------------------------------------
// psm_front
// Edge differences, cross product and common power-of-two scaling.
// ----------------------------------------------------------------------------
module psm_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [8:0][31:0]      pts_i,
  output logic                  push_o,
  output psm_pkg::q_entry_t     entry_o
);

  logic [3:0]                 vld_q;
  logic signed [32:0]         v1_q [3];
  logic signed [32:0]         v2_q [3];
  logic [2:0][31:0]           c1_q, c2_q, c3_q;
  logic signed [65:0]         m_q [6];
  logic [psm_pkg::MagW-1:0]   mag_q [3];
  logic [2:0]                 neg_q;
  logic [psm_pkg::MagW-1:0]   cr [3];
  logic [psm_pkg::MagW-1:0]   orm;
  logic [6:0]                 blen;
  psm_pkg::q_entry_t          ent_d, ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], in_valid_i};
    end
  end

  // differences A-B and B-C
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      v1_q[i] <= $signed({pts_i[i][31], pts_i[i]}) - $signed({pts_i[3+i][31], pts_i[3+i]});
      v2_q[i] <= $signed({pts_i[3+i][31], pts_i[3+i]}) -
                 $signed({pts_i[6+i][31], pts_i[6+i]});
      c1_q[i] <= pts_i[6+i];
    end
  end

  // six partial products of the cross product
  always_ff @(posedge clk_i) begin
    m_q[0] <= v1_q[1] * v2_q[2];
    m_q[1] <= v1_q[2] * v2_q[1];
    m_q[2] <= v1_q[2] * v2_q[0];
    m_q[3] <= v1_q[0] * v2_q[2];
    m_q[4] <= v1_q[0] * v2_q[1];
    m_q[5] <= v1_q[1] * v2_q[0];
    c2_q   <= c1_q;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr[i] = {m_q[2*i][65], m_q[2*i]} - {m_q[2*i+1][65], m_q[2*i+1]};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      neg_q[i] <= cr[i][psm_pkg::MagW-1];
      mag_q[i] <= cr[i][psm_pkg::MagW-1] ? (~cr[i] + 1'b1) : cr[i];
    end
    c3_q <= c2_q;
  end

  // bit length of the largest magnitude
  always_comb begin
    orm  = mag_q[0] | mag_q[1] | mag_q[2];
    blen = '0;
    for (int b = 0; b < psm_pkg::MagW; b++) begin
      if (orm[b]) blen = 7'(b + 1);
    end
  end

  always_comb begin
    logic [psm_pkg::MagW-1:0] t;
    ent_d = '0;
    for (int i = 0; i < 3; i++) begin
      if (blen > 7'd31) begin
        t = mag_q[i] >> (blen - 7'd31);
      end else begin
        t = mag_q[i] << (7'd31 - blen);
      end
      ent_d.sc[i] = t[psm_pkg::ScW-1:0];
    end
    ent_d.neg = neg_q;
    ent_d.c   = c3_q;
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign push_o  = vld_q[3];
  assign entry_o = ent_q;

endmodule

// File: hdl/psm_queue.sv
// ----------------------------------------------------------------------------
// psm_queue
// Short FIFO between front and back.
// ----------------------------------------------------------------------------
module psm_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  psm_pkg::q_entry_t push_data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output psm_pkg::q_entry_t data_o
);

  psm_pkg::q_entry_t          mem_q [psm_pkg::QDepth];
  logic [psm_pkg::QAw-1:0]    wr_q, rd_q;
  logic [psm_pkg::CrdW-1:0]   cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + psm_pkg::CrdW'(push_i) - psm_pkg::CrdW'(pop_i);
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

endmodule

// File: hdl/psm_back.sv
// ----------------------------------------------------------------------------
// psm_back
// Length, normal, plane offset, dot product and matrix rows.
// ----------------------------------------------------------------------------
module psm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  psm_pkg::q_entry_t q_data_i,
  output logic              q_pop_o,
  input  logic [3:0][31:0]  light_i,
  output logic              res_valid_o,
  output psm_pkg::row_t     res_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SQ    = 9'b000000010,
    S_SUM   = 9'b000000100,
    S_ROOT  = 9'b000001000,
    S_DPREP = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_DMUL  = 9'b001000000,
    S_DSUM  = 9'b010000000,
    S_ROW   = 9'b100000000
  } state_e;

  state_e                    state_q, state_d;
  logic [4:0]                cnt_q;
  logic [2:0][30:0]          sc_q;
  logic [2:0]                neg_q;
  logic [2:0][31:0]          c_q;
  logic [61:0]               sq_q [3];
  logic [63:0]               rad_q, root_q, bit_q, trial;
  logic [31:0]               len_q, len_d;
  logic [31:0]               rem_q [3];
  logic [30:0]               numl_q [3];
  logic [30:0]               quo_q [3];
  logic signed [31:0]        nrm_q [3];
  logic signed [31:0]        nrm_d [3];
  logic signed [63:0]        dp_q [3];
  logic signed [65:0]        plane3_q;
  logic signed [64:0]        phi_q [4];
  logic signed [65:0]        plo_q [4];
  logic [1:0]                rk_q;
  logic                      rv_q;
  logic                      dv_q;
  logic signed [psm_pkg::AccW-1:0] dot_q;
  psm_pkg::row_t             res_q;
  logic                      res_v_q;

  function automatic logic signed [65:0] plane_of(input logic [1:0] k,
                                                  input logic signed [31:0] n0,
                                                  input logic signed [31:0] n1,
                                                  input logic signed [31:0] n2,
                                                  input logic signed [65:0] p3);
    logic signed [65:0] r;
    unique case (k)
      2'd0:    r = {{18{n0[31]}}, n0, 16'd0};
      2'd1:    r = {{18{n1[31]}}, n1, 16'd0};
      2'd2:    r = {{18{n2[31]}}, n2, 16'd0};
      default: r = p3;
    endcase
    return r;
  endfunction

  function automatic logic signed [psm_pkg::AccW-1:0] join_prod(
      input logic signed [64:0] ph, input logic signed [65:0] pl);
    return {{6{ph[64]}}, ph, 33'd0} + {{38{pl[65]}}, pl};
  endfunction

  assign trial   = root_q + bit_q;
  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;
  assign len_d   = (root_q[31:0] == '0) ? 32'd1 : root_q[31:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nrm_d[i] = neg_q[i] ? -$signed({1'b0, quo_q[i]}) : $signed({1'b0, quo_q[i]});
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (q_valid_i) state_d = S_SQ;
      S_SQ:    state_d = S_SUM;
      S_SUM:   state_d = S_ROOT;
      S_ROOT:  if (cnt_q == 5'd31) state_d = S_DPREP;
      S_DPREP: state_d = S_DIV;
      S_DIV:   if (cnt_q == 5'd30) state_d = S_DMUL;
      S_DMUL:  state_d = S_DSUM;
      S_DSUM:  state_d = S_ROW;
      S_ROW:   if (cnt_q == 5'd7) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
      dv_q    <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_d != state_q) ? 5'd0 : cnt_q + 1'b1;
      dv_q    <= (state_q == S_ROW) && (cnt_q < 5'd4);
      rv_q    <= (state_q == S_ROW) && (cnt_q >= 5'd4);
      res_v_q <= rv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        sc_q  <= q_data_i.sc;
        neg_q <= q_data_i.neg;
        c_q   <= q_data_i.c;
      end
      S_SQ: begin
        for (int i = 0; i < 3; i++) sq_q[i] <= sc_q[i] * sc_q[i];
      end
      S_SUM: begin
        rad_q  <= 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
        root_q <= '0;
        bit_q  <= 64'd1 << 62;
      end
      S_ROOT: begin
        // one result bit of the floor square root
        if (rad_q >= trial) begin
          rad_q  <= rad_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_DPREP: begin
        len_q <= len_d;
        for (int i = 0; i < 3; i++) begin
          logic [61:0] num;
          num = {1'b0, sc_q[i], 30'd0} + 62'(len_d >> 1);
          rem_q[i]  <= {1'b0, num[61:31]};
          numl_q[i] <= num[30:0];
          quo_q[i]  <= '0;
        end
      end
      S_DIV: begin
        // one quotient bit per cycle for all three components
        for (int i = 0; i < 3; i++) begin
          logic [32:0] r2;
          logic        ge;
          r2 = {rem_q[i], numl_q[i][30]};
          ge = (r2 >= {1'b0, len_q});
          rem_q[i]  <= ge ? 32'(r2 - {1'b0, len_q}) : r2[31:0];
          numl_q[i] <= numl_q[i] << 1;
          quo_q[i]  <= {quo_q[i][29:0], ge};
        end
      end
      S_DMUL: begin
        for (int i = 0; i < 3; i++) begin
          nrm_q[i] <= nrm_d[i];
          dp_q[i]  <= nrm_d[i] * $signed(c_q[i]);
        end
      end
      S_DSUM: begin
        plane3_q <= -({{2{dp_q[0][63]}}, dp_q[0]} + {{2{dp_q[1][63]}}, dp_q[1]} +
                      {{2{dp_q[2][63]}}, dp_q[2]});
      end
      default: ;
    endcase
  end

  // row phase: first the diagonal products are summed into dot,
  // then the four rows are issued
  always_ff @(posedge clk_i) begin
    if (state_q == S_ROW) begin
      for (int j = 0; j < 4; j++) begin
        logic [1:0]         k;
        logic [1:0]         lj;
        logic signed [65:0] p;
        k  = cnt_q[1:0];
        lj = (cnt_q < 5'd4) ? cnt_q[1:0] : 2'(j);
        p  = plane_of(k, nrm_q[0], nrm_q[1], nrm_q[2], plane3_q);
        phi_q[j] <= $signed(p[65:33]) * $signed(light_i[lj]);
        plo_q[j] <= $signed({1'b0, p[32:0]}) * $signed(light_i[lj]);
      end
      rk_q <= cnt_q[1:0];
    end
    if ((state_q == S_ROW) && (cnt_q == 5'd0)) begin
      dot_q <= '0;
    end else if (dv_q) begin
      dot_q <= dot_q + join_prod(phi_q[0], plo_q[0]);
    end
    if (rv_q) begin
      for (int j = 0; j < 4; j++) begin
        res_q.entry[j] <= psm_pkg::to_entry(((rk_q == 2'(j)) ? dot_q : '0) -
                                             join_prod(phi_q[j], plo_q[j]));
      end
      res_q.row_index <= rk_q;
      res_q.last_row  <= (rk_q == 2'd3);
    end
  end

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

endmodule
